// File: src/tzad_pkg.sv
// Shared constants, zone rectangles and types for the touch zone action debounce block.
package tzad_pkg;

    localparam int NUM_ZONES   = 5;
    localparam int RECT_COUNT  = 5;
    localparam int ZONE_RECTS  = (NUM_ZONES < RECT_COUNT) ? NUM_ZONES : RECT_COUNT;
    localparam int COORD_W     = 10;
    localparam int TIME_W      = 32;
    localparam int LOCK_W      = 16;
    localparam int MASK_W      = 5;

    localparam logic [LOCK_W-1:0] LOCKOUT_RESET = 16'd300;

    // Zone bounds as half-open ranges [lo, hi): clear, pause, save, load, reset
    localparam logic [COORD_W-1:0] ZONE_X_LO [RECT_COUNT] =
        '{10'd20, 10'd116, 10'd212, 10'd308, 10'd20};
    localparam logic [COORD_W-1:0] ZONE_X_HI [RECT_COUNT] =
        '{10'd106, 10'd202, 10'd298, 10'd394, 10'd140};
    localparam logic [COORD_W-1:0] ZONE_Y_LO [RECT_COUNT] =
        '{10'd18, 10'd18, 10'd18, 10'd18, 10'd68};
    localparam logic [COORD_W-1:0] ZONE_Y_HI [RECT_COUNT] =
        '{10'd58, 10'd58, 10'd58, 10'd58, 10'd104};

    typedef logic [NUM_ZONES-1:0] t_zone_mask;

    // Per-beat control from the input stage to the action core
    typedef struct packed {
        logic step;
        logic has_point;
        logic touched;
        logic frame_end;
    } t_step_ctl;

endpackage

// File: src/tzad_if.sv
// Handshake channel interfaces: touch point input, action output, lockout write.
interface tzad_in_if import tzad_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic               has_point;
    logic               touched;
    logic               frame_end;
    logic [TIME_W-1:0]  now_ms;

    modport source (output valid, x_coord, y_coord, has_point, touched, frame_end, now_ms,
                    input ready);
    modport sink   (input valid, x_coord, y_coord, has_point, touched, frame_end, now_ms,
                    output ready);
endinterface

interface tzad_out_if import tzad_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] action_mask;

    modport source (output valid, action_mask, input ready);
    modport sink   (input valid, action_mask, output ready);
endinterface

interface tzad_cfg_if import tzad_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LOCK_W-1:0] lockout_ms;

    modport source (output valid, lockout_ms, input ready);
    modport sink   (input valid, lockout_ms, output ready);
endinterface

// File: src/tzad_zone_hit.sv
// Hit test of one touch point against every zone rectangle.
module tzad_zone_hit import tzad_pkg::*; (
    input  logic [COORD_W-1:0] i_x,
    input  logic [COORD_W-1:0] i_y,
    output t_zone_mask         o_hits
);

    // Compare the point against each rectangle in parallel
    for (genvar g = 0; g < NUM_ZONES; g++) begin : g_zone
        if (g < ZONE_RECTS) begin : g_rect
            assign o_hits[g] = (i_x >= ZONE_X_LO[g]) && (i_x < ZONE_X_HI[g]) &&
                               (i_y >= ZONE_Y_LO[g]) && (i_y < ZONE_Y_HI[g]);
        end else begin : g_none
            assign o_hits[g] = 1'b0;
        end
    end

endmodule

// File: src/tzad_action_core.sv
// Frame hit gathering, edge detect and per-zone lockout with fire timestamps.
module tzad_action_core import tzad_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LOCK_W-1:0] i_cfg_lockout,
    input  t_step_ctl         i_ctl,
    input  t_zone_mask        i_hits,
    input  logic [TIME_W-1:0] i_now,
    output t_zone_mask        o_fire
);

    logic [LOCK_W-1:0] r_lockout;
    t_zone_mask        r_frame_hits;
    t_zone_mask        r_prev_pressed;
    logic [TIME_W-1:0] r_last_fire [NUM_ZONES];

    t_zone_mask        n_frame_hits;
    t_zone_mask        pressed;
    t_zone_mask        fire;

    // Merge this beat's point into the frame and form the pressed mask
    assign n_frame_hits = r_frame_hits | (i_ctl.has_point ? i_hits : '0);
    assign pressed      = i_ctl.touched ? n_frame_hits : '0;

    // Fire on a new press once the lockout window has elapsed
    for (genvar g = 0; g < NUM_ZONES; g++) begin : g_fire
        logic [TIME_W-1:0] elapsed;
        assign elapsed = i_now - r_last_fire[g];
        assign fire[g] = pressed[g] && !r_prev_pressed[g] &&
                         (elapsed >= {{(TIME_W-LOCK_W){1'b0}}, r_lockout});
    end

    assign o_fire = fire;

    // Hold the lockout setting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout <= LOCKOUT_RESET;
        end else if (i_cfg_we) begin
            r_lockout <= i_cfg_lockout;
        end
    end

    // Advance frame state on each step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_hits   <= '0;
            r_prev_pressed <= '0;
        end else if (i_ctl.step) begin
            if (i_ctl.frame_end) begin
                r_frame_hits   <= '0;
                r_prev_pressed <= pressed;
            end else begin
                r_frame_hits   <= n_frame_hits;
            end
        end
    end

    // Stamp the fire time of each zone that fires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_ZONES; k++) begin
                r_last_fire[k] <= '0;
            end
        end else if (i_ctl.step && i_ctl.frame_end) begin
            for (int k = 0; k < NUM_ZONES; k++) begin
                if (fire[k]) begin
                    r_last_fire[k] <= i_now;
                end
            end
        end
    end

    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.step && i_ctl.frame_end |=> r_frame_hits == '0)
        else $error("frame hits not cleared after frame end");

    a_fire_is_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.step && i_ctl.frame_end |-> (fire & r_prev_pressed) == '0)
        else $error("action fired on a zone held from the previous frame");

    a_fire_stamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.step && i_ctl.frame_end && fire[0] |=> r_last_fire[0] == $past(i_now))
        else $error("fire time not recorded for first zone");

endmodule

// File: src/touch_zone_action_debounce.sv
// Top level: input stage, zone hit test, action core and result register.
//
//  channel  dir  beat payload                                          handshake
//  i_in     in   x_coord, y_coord, has_point, touched, frame_end, now_ms  valid/ready
//  o_out    out  action_mask                                           valid/ready
//  i_cfg    in   lockout_ms                                            valid/ready
//
// Each beat is held in the input register, where the zone test and action core
// work on it combinationally; one beat is taken every cycle unless a frame-end beat
// is stalled, and a frame-end beat loads the result register as it leaves the input register.
// Reset (i_rst_n low, synchronous) empties both registers, clears frame state and fire
// times, and sets lockout_ms to 300. The configuration channel is always ready.
// A result waiting in the output register stalls only a frame-end beat in the input
// register; beats without frame end keep flowing.
module touch_zone_action_debounce import tzad_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tzad_in_if.sink     i_in,
    tzad_out_if.source  o_out,
    tzad_cfg_if.sink    i_cfg
);

    logic               r_s1_valid;
    logic [COORD_W-1:0] r_s1_x;
    logic [COORD_W-1:0] r_s1_y;
    logic               r_s1_has_point;
    logic               r_s1_touched;
    logic               r_s1_frame_end;
    logic [TIME_W-1:0]  r_s1_now;

    logic               r_out_valid;
    t_zone_mask         r_out_mask;

    logic               out_free;
    logic               s1_go;
    logic               in_ready;
    t_zone_mask         hits;
    t_zone_mask         fire;
    t_step_ctl          ctl;

    // Let the input stage move unless a frame end would overwrite a waiting result
    assign out_free = !r_out_valid || o_out.ready;
    assign s1_go    = r_s1_valid && (!r_s1_frame_end || out_free);
    assign in_ready = !r_s1_valid || s1_go;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    // Hold the accepted beat in the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_s1_x         <= i_in.x_coord;
            r_s1_y         <= i_in.y_coord;
            r_s1_has_point <= i_in.has_point;
            r_s1_touched   <= i_in.touched;
            r_s1_frame_end <= i_in.frame_end;
            r_s1_now       <= i_in.now_ms;
        end
    end

    tzad_zone_hit u_zone_hit (
        .i_x    (r_s1_x),
        .i_y    (r_s1_y),
        .o_hits (hits)
    );

    assign ctl = '{step: s1_go, has_point: r_s1_has_point,
                   touched: r_s1_touched, frame_end: r_s1_frame_end};

    tzad_action_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_lockout (i_cfg.lockout_ms),
        .i_ctl         (ctl),
        .i_hits        (hits),
        .i_now         (r_s1_now),
        .o_fire        (fire)
    );

    // Load the result on a frame end, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_frame_end) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_frame_end) begin
            r_out_mask <= fire;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.action_mask = MASK_W'(r_out_mask);

    a_result_from_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_frame_end) && $past(s1_go))
        else $error("result appeared without a frame end beat");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !(s1_go && r_s1_frame_end))
        else $error("waiting result overwritten");

endmodule

// File: tb/tb_touch_zone_action_debounce.sv
// Testbench for the touch zone action debounce block: directed and random touch frames.
`timescale 1ns / 1ps

module tb_touch_zone_action_debounce import tzad_pkg::*; ();

    localparam int IDLE_PCT     = 23;
    localparam int STALL_LIMIT  = 5000;
    localparam int SETTLE_TICKS = 4;
    localparam int RECTS        = (NUM_ZONES < 5) ? NUM_ZONES : 5;

    // Zone rectangles {left, top, width, height}: clear, pause, save, load, reset
    localparam int ZX [5] = '{20, 116, 212, 308, 20};
    localparam int ZY [5] = '{18, 18, 18, 18, 68};
    localparam int ZW [5] = '{86, 86, 86, 86, 120};
    localparam int ZH [5] = '{40, 40, 40, 40, 36};

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               has_point;
        logic               touched;
        logic               frame_end;
        logic [TIME_W-1:0]  now_ms;
    } t_touch_beat;

    logic clk;
    logic rst_n;

    tzad_in_if  in_ch ();
    tzad_out_if out_ch ();
    tzad_cfg_if cfg_ch ();

    touch_zone_action_debounce dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Predictor state
    logic [MASK_W-1:0] zone_hits;
    logic [MASK_W-1:0] pressed_prev;
    logic [TIME_W-1:0] fired_at [5];
    logic [LOCK_W-1:0] lockout_now;
    logic [MASK_W-1:0] expected_actions [$];

    // Run bookkeeping
    logic [TIME_W-1:0] clock_ms;
    bit                steady_flow;
    int                failures;
    int                beats_sent;
    int                frames_seen;
    int                actions_fired;
    int                lockout_writes;
    int                idle_ticks;

    always #2 clk = ~clk;

    // Zones that one point lands in
    function automatic logic [MASK_W-1:0] zones_hit(logic [COORD_W-1:0] px,
                                                    logic [COORD_W-1:0] py);
        logic [MASK_W-1:0] m;
        m = '0;
        for (int k = 0; k < RECTS; k++) begin
            if (px >= ZX[k] && px < ZX[k] + ZW[k] && py >= ZY[k] && py < ZY[k] + ZH[k])
                m[k] = 1'b1;
        end
        return m;
    endfunction

    // Fold one accepted beat into the frame state; queue the action mask on frame end
    task automatic predict_frame_actions(input t_touch_beat b);
        logic [MASK_W-1:0] pressed;
        logic [MASK_W-1:0] fired;
        logic [TIME_W-1:0] age;
        if (b.has_point)
            zone_hits = zone_hits | zones_hit(b.x, b.y);
        if (b.frame_end) begin
            pressed = b.touched ? zone_hits : '0;
            fired = '0;
            for (int k = 0; k < RECTS; k++) begin
                age = b.now_ms - fired_at[k];
                if (pressed[k] && !pressed_prev[k] && age >= lockout_now) begin
                    fired_at[k] = b.now_ms;
                    fired[k] = 1'b1;
                end
            end
            pressed_prev = pressed;
            zone_hits = '0;
            expected_actions.push_back(fired);
            frames_seen++;
            actions_fired += $countones(fired);
        end
    endtask

    // Drive one beat, idling at random first; valid stays high after the handshake
    task automatic send_beat(input t_touch_beat b);
        @(negedge clk);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.x_coord   <= b.x;
        in_ch.y_coord   <= b.y;
        in_ch.has_point <= b.has_point;
        in_ch.touched   <= b.touched;
        in_ch.frame_end <= b.frame_end;
        in_ch.now_ms    <= b.now_ms;
        do @(posedge clk); while (!in_ch.ready);
        predict_frame_actions(b);
        beats_sent++;
    endtask

    task automatic touch_at(input int px, input int py, input bit hp, input bit tch,
                            input bit fe, input logic [TIME_W-1:0] t);
        t_touch_beat b;
        b.x = COORD_W'(px);
        b.y = COORD_W'(py);
        b.has_point = hp;
        b.touched = tch;
        b.frame_end = fe;
        b.now_ms = t;
        send_beat(b);
    endtask

    // Hold the sender until every queued action mask has come out
    task automatic wait_results_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_actions.size() != 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_lockout(input logic [LOCK_W-1:0] v);
        wait_results_drained();
        @(negedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.lockout_ms <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        lockout_now = v;
        lockout_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly points inside a zone, some on the borders, the rest anywhere
    function automatic void pick_point(output logic [COORD_W-1:0] px,
                                       output logic [COORD_W-1:0] py);
        int k;
        int mode;
        k = $urandom_range(4);
        mode = $urandom_range(99);
        if (mode < 60) begin
            px = COORD_W'(ZX[k] + $urandom_range(ZW[k] - 1));
            py = COORD_W'(ZY[k] + $urandom_range(ZH[k] - 1));
        end else if (mode < 80) begin
            case ($urandom_range(3))
                0: px = COORD_W'(ZX[k] - 1);
                1: px = COORD_W'(ZX[k]);
                2: px = COORD_W'(ZX[k] + ZW[k] - 1);
                default: px = COORD_W'(ZX[k] + ZW[k]);
            endcase
            case ($urandom_range(3))
                0: py = COORD_W'(ZY[k] - 1);
                1: py = COORD_W'(ZY[k]);
                2: py = COORD_W'(ZY[k] + ZH[k] - 1);
                default: py = COORD_W'(ZY[k] + ZH[k]);
            endcase
        end else begin
            px = COORD_W'($urandom);
            py = COORD_W'($urandom);
        end
    endfunction

    // One frame of one to four beats, closed by a frame-end beat
    task automatic send_random_frame();
        t_touch_beat b;
        int n;
        int r;
        bit blank;
        n = $urandom_range(1, 4);
        r = $urandom_range(99);
        if (r < 5)
            clock_ms = $urandom;
        else if (r < 8)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(int'(lockout_now));
        else if (r >= 15)
            clock_ms = clock_ms + $urandom_range(2 * int'(lockout_now) + 2);
        blank = ($urandom_range(99) < 20);
        for (int i = 0; i < n; i++) begin
            pick_point(b.x, b.y);
            b.has_point = !blank && ($urandom_range(9) != 0);
            b.touched   = ($urandom_range(99) < 90);
            b.frame_end = (i == n - 1);
            b.now_ms    = (i == n - 1) ? clock_ms : $urandom;
            send_beat(b);
        end
    endtask

    task automatic send_random_frames(input int beat_count);
        int stop_at;
        stop_at = beats_sent + beat_count;
        while (beats_sent < stop_at) send_random_frame();
    endtask

    // A press right after reset falls inside the lockout from time zero
    task automatic test_power_on_lockout();
        touch_at(50, 30, 1, 1, 1, 5);
        touch_at(0, 0, 0, 1, 1, 6);
    endtask

    // Zone borders, all five zones at once, ignored points and untouched frames
    task automatic test_zone_edges();
        touch_at(19, 18, 1, 1, 0, 32'h0);
        touch_at(106, 30, 1, 1, 0, 32'h0);
        touch_at(50, 58, 1, 1, 1, 1000);
        touch_at(105, 57, 1, 1, 1, 1000);
        for (int k = 0; k < 5; k++)
            touch_at(ZX[k], ZY[k], 1, 1, k == 4, 2000);
        touch_at(30, 80, 0, 1, 1, 3000);
        touch_at(20, 68, 1, 1, 0, 32'hFFFF_FFFF);
        touch_at(1023, 1023, 1, 0, 1, 3000);
    endtask

    // One millisecond short of the lockout, then exactly on it
    task automatic test_lockout_window();
        touch_at(60, 40, 1, 1, 1, 1299);
        touch_at(60, 40, 0, 1, 1, 1300);
        touch_at(60, 40, 1, 1, 1, 1300);
    endtask

    // Timestamps that wrap through zero
    task automatic test_timestamp_wrap();
        touch_at(150, 30, 1, 1, 1, 32'hFFFF_FFFF);
        touch_at(150, 30, 0, 1, 1, 32'h0);
        touch_at(150, 30, 1, 1, 1, 298);
        touch_at(150, 30, 0, 1, 1, 299);
        touch_at(150, 30, 1, 1, 1, 299);
        clock_ms = 299;
    endtask

    // Random frames under several lockout settings, the extremes among them
    task automatic test_lockout_settings();
        logic [LOCK_W-1:0] settings [5];
        settings = '{16'd0, 16'hFFFF, 16'd0, 16'd1, 16'd300};
        settings[2] = LOCK_W'($urandom_range(1, 16'hFFFE));
        foreach (settings[i]) begin
            write_lockout(settings[i]);
            send_random_frames(250);
        end
    endtask

    // A stretch with no idling on either side, a full hold-off, then more traffic
    task automatic test_stall_pressure();
        steady_flow = 1'b1;
        send_random_frames(120);
        steady_flow = 1'b0;
        wait_results_drained();
        send_random_frames(130);
    endtask

    // Receiver backpressure
    always @(negedge clk)
        out_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);

    // Compare each action beat against the oldest prediction
    always @(posedge clk) begin : check_actions
        logic [MASK_W-1:0] want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_actions.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected action beat: got %b", out_ch.action_mask);
            end else begin
                want = expected_actions.pop_front();
                if (out_ch.action_mask !== want) begin
                    failures++;
                    if (failures <= 10)
                        $display("action_mask mismatch: expected %b, got %b",
                                 want, out_ch.action_mask);
                end
            end
        end
    end

    // End the run when no beat has moved on any channel for too long
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_ticks <= 0;
        end else if (idle_ticks >= STALL_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                     idle_ticks, expected_actions.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_ticks <= idle_ticks + 1;
        end
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.x_coord = '0;
        in_ch.y_coord = '0;
        in_ch.has_point = 1'b0;
        in_ch.touched = 1'b0;
        in_ch.frame_end = 1'b0;
        in_ch.now_ms = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.lockout_ms = '0;
        zone_hits = '0;
        pressed_prev = '0;
        foreach (fired_at[k]) fired_at[k] = '0;
        lockout_now = 16'd300;
        clock_ms = '0;
        steady_flow = 1'b0;
        failures = 0;
        beats_sent = 0;
        frames_seen = 0;
        actions_fired = 0;
        lockout_writes = 0;
        idle_ticks = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_power_on_lockout();
        test_zone_edges();
        test_lockout_window();
        test_timestamp_wrap();
        test_lockout_settings();
        test_stall_pressure();

        // Drain and let the pipeline settle
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_actions.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (expected_actions.size() != 0) begin
            failures += expected_actions.size();
            $display("%0d action beats never arrived", expected_actions.size());
        end

        $display("Covered %0d touch beats in %0d frames, %0d zone actions fired,",
                 beats_sent, frames_seen, actions_fired);
        $display("across %0d lockout writes including 0 and 65535; %0d failures",
                 lockout_writes, failures);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
